@@ sv/hct_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the hysteresis cooling thermostat.
// No dependencies; imported by every module of the block.
package hct_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 12;
  localparam int TempW    = 12;
  localparam int CodeW    = 10;
  localparam int MarginW  = 8;
  // temperature +/- margin fits with one extra bit
  localparam int CmpW     = TempW + 1;

  // supply modes; any other code runs as AC
  localparam logic [1:0] MODE_GAS = 2'd0;
  localparam logic [1:0] MODE_DC  = 2'd1;
  localparam logic [1:0] MODE_AC  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_OP_MODE     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SET_TEMP    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ON_MARGIN   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_OFF_MARGIN  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_GAS_LOW     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_DC_LOW      = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_FLAME_OUT   = 3'd6;

  typedef struct packed {
    logic [1:0]         op_mode;
    logic [TempW-1:0]   set_temp;
    logic [MarginW-1:0] on_margin;
    logic [MarginW-1:0] off_margin;
    logic [CodeW-1:0]   gas_low_limit;
    logic [CodeW-1:0]   dc_low_limit;
    logic [CodeW-1:0]   flame_out_limit;
  } cfg_t;

  typedef struct packed {
    logic [TempW-1:0] temperature;
    logic             sensor_error;
    logic [CodeW-1:0] dc_voltage_code;
    logic [CodeW-1:0] gas_voltage_code;
    logic [CodeW-1:0] flame_code;
  } meas_t;

  typedef struct packed {
    logic relay_dc_on;
    logic relay_ac_on;
    logic cooling_active;
    logic low_battery;
    logic temp_fault;
    logic alarm;
  } result_t;

endpackage

@@ sv/hysteresis_cooling_thermostat.sv @@
`timescale 1ns / 1ps
// Hysteresis cooling thermostat, top level: input register, decision logic, output register.
// An input beat is captured in the input register; its result is captured in the output register.
// Throughput: one round per cycle; a stalled output holds the pipe, set by the output register.
// Reset (synchronous, rst_n low): pipe empty, relays off, running off, battery-low set,
// flame-seen clear, configuration at its defaults. Depends on hct_pkg, hct_cfg, hct_core.
module hysteresis_cooling_thermostat (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hct_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [hct_pkg::CfgDataW-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [11:0]            in_temperature,
  input  logic                          in_sensor_error,
  input  logic [9:0]                    in_dc_voltage_code,
  input  logic [9:0]                    in_gas_voltage_code,
  input  logic [9:0]                    in_flame_code,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_relay_dc_on,
  output logic                          out_relay_ac_on,
  output logic                          out_cooling_active,
  output logic                          out_low_battery,
  output logic                          out_temp_fault,
  output logic                          out_alarm
);
  import hct_pkg::*;

  cfg_t    cfg;
  meas_t   meas_r;
  logic    meas_vld_r;
  result_t res_r, res_c;
  logic    res_vld_r;
  logic    advance, out_free;

  hct_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_free = !res_vld_r || out_ready;
  assign advance  = meas_vld_r && out_free;
  assign in_ready = !meas_vld_r || out_free;

  hct_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .cfg     (cfg),
    .meas    (meas_r),
    .result  (res_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      if (in_ready) meas_vld_r <= in_valid;
      if (out_free) res_vld_r  <= meas_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      meas_r.temperature      <= in_temperature;
      meas_r.sensor_error     <= in_sensor_error;
      meas_r.dc_voltage_code  <= in_dc_voltage_code;
      meas_r.gas_voltage_code <= in_gas_voltage_code;
      meas_r.flame_code       <= in_flame_code;
    end
    if (advance) res_r <= res_c;
  end

  assign out_valid          = res_vld_r;
  assign out_relay_dc_on    = res_r.relay_dc_on;
  assign out_relay_ac_on    = res_r.relay_ac_on;
  assign out_cooling_active = res_r.cooling_active;
  assign out_low_battery    = res_r.low_battery;
  assign out_temp_fault     = res_r.temp_fault;
  assign out_alarm          = res_r.alarm;

endmodule

@@ sv/hct_cfg.sv @@
`timescale 1ns / 1ps
// Configuration register file of the thermostat.
// Depends on hct_pkg.
module hct_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [hct_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [hct_pkg::CfgDataW-1:0]  cfg_data,
  output hct_pkg::cfg_t                 cfg
);
  import hct_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_OP_MODE:    cfg_nxt.op_mode         = cfg_data[1:0];
        CFG_SET_TEMP:   cfg_nxt.set_temp        = cfg_data[TempW-1:0];
        CFG_ON_MARGIN:  cfg_nxt.on_margin       = cfg_data[MarginW-1:0];
        CFG_OFF_MARGIN: cfg_nxt.off_margin      = cfg_data[MarginW-1:0];
        CFG_GAS_LOW:    cfg_nxt.gas_low_limit   = cfg_data[CodeW-1:0];
        CFG_DC_LOW:     cfg_nxt.dc_low_limit    = cfg_data[CodeW-1:0];
        CFG_FLAME_OUT:  cfg_nxt.flame_out_limit = cfg_data[CodeW-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.op_mode         <= MODE_GAS;
      cfg_r.set_temp        <= '0;
      cfg_r.on_margin       <= MarginW'(8);
      cfg_r.off_margin      <= MarginW'(16);
      cfg_r.gas_low_limit   <= CodeW'(723);
      cfg_r.dc_low_limit    <= CodeW'(672);
      cfg_r.flame_out_limit <= CodeW'(409);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ sv/hct_core.sv @@
`timescale 1ns / 1ps
// Thermostat state and per-round decision logic.
// Depends on hct_pkg; state advances only on a beat that moves to the output.
module hct_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  hct_pkg::cfg_t     cfg,
  input  hct_pkg::meas_t    meas,
  output hct_pkg::result_t  result
);
  import hct_pkg::*;

  logic dc_relay_r, dc_relay_nxt;
  logic ac_relay_r, ac_relay_nxt;
  logic running_r, running_nxt;
  logic bat_low_r, bat_low_nxt;
  logic flame_seen_r, flame_seen_nxt;

  logic                  is_gas, is_dc;
  logic signed [CmpW-1:0] temp_s, off_thr, on_thr;
  logic                  off_hit, on_hit;
  logic                  rel_prev, rel, run_t;

  always_comb begin
    is_gas  = (cfg.op_mode == MODE_GAS);
    is_dc   = (cfg.op_mode == MODE_DC);
    temp_s  = CmpW'($signed(meas.temperature));
    off_thr = CmpW'($signed(cfg.set_temp)) - $signed({1'b0, 4'd0, cfg.off_margin});
    on_thr  = CmpW'($signed(cfg.set_temp)) + $signed({1'b0, 4'd0, cfg.on_margin});
    off_hit = (temp_s <= off_thr);
    on_hit  = (temp_s >= on_thr);

    // hysteresis uses the previous round's low-battery flag
    rel_prev = is_dc ? dc_relay_r : ac_relay_r;
    if (off_hit || bat_low_r) begin
      rel   = 1'b0;
      run_t = 1'b0;
    end else if (on_hit) begin
      rel   = 1'b1;
      run_t = 1'b1;
    end else begin
      rel   = rel_prev;
      run_t = running_r;
    end

    dc_relay_nxt = !is_gas && is_dc && rel;
    ac_relay_nxt = !is_gas && !is_dc && rel;

    if (is_gas) begin
      bat_low_nxt = (meas.gas_voltage_code < cfg.gas_low_limit);
    end else if (is_dc) begin
      bat_low_nxt = (meas.dc_voltage_code < cfg.dc_low_limit);
    end else begin
      bat_low_nxt = 1'b0;
    end

    if (is_gas) begin
      running_nxt    = (meas.flame_code <= cfg.flame_out_limit);
      flame_seen_nxt = flame_seen_r || running_nxt;
    end else begin
      running_nxt    = run_t;
      flame_seen_nxt = flame_seen_r;
    end

    result.relay_dc_on    = dc_relay_nxt;
    result.relay_ac_on    = ac_relay_nxt;
    result.cooling_active = running_nxt;
    result.low_battery    = bat_low_nxt;
    result.temp_fault     = meas.sensor_error;
    // low battery is already zero in AC mode
    result.alarm          = bat_low_nxt || meas.sensor_error
                            || (flame_seen_nxt && !running_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_relay_r   <= 1'b0;
      ac_relay_r   <= 1'b0;
      running_r    <= 1'b0;
      bat_low_r    <= 1'b1;
      flame_seen_r <= 1'b0;
    end else if (advance) begin
      dc_relay_r   <= dc_relay_nxt;
      ac_relay_r   <= ac_relay_nxt;
      running_r    <= running_nxt;
      bat_low_r    <= bat_low_nxt;
      flame_seen_r <= flame_seen_nxt;
    end
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for hysteresis_cooling_thermostat: directed rounds, then random phases,
// each beat scored against an in-bench model or a typed-in result. Depends on hct_pkg and the RTL.
module testbench;
  import hct_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;  // unused code, runs as AC
  localparam int TEMP_MIN = -880;
  localparam int TEMP_MAX = 2000;
  localparam int CODE_MAX = 1023;
  localparam int PHASES = 12;
  localparam int ROUNDS_PER_PHASE = 152;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_PRINTS = 50;

  localparam cfg_t CFG_DEFAULTS = '{op_mode: MODE_GAS, set_temp: '0, on_margin: 8'd8,
                                    off_margin: 8'd16, gas_low_limit: 10'd723,
                                    dc_low_limit: 10'd672, flame_out_limit: 10'd409};
  localparam logic [1:0] PHASE_MODES [PHASES] = '{MODE_DC, MODE_AC, MODE_GAS, MODE_DC,
                                                   MODE_GAS, MODE_AC, MODE_DC, MODE_SPARE,
                                                   MODE_GAS, MODE_DC, MODE_AC, MODE_DC};

  typedef struct {
    logic [1:0] mode;
    meas_t      m;
    bit         pinned;
    result_t    want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = CFG_OP_MODE;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic signed [11:0]  in_temperature = '0;
  logic                in_sensor_error = 1'b0;
  logic [9:0]          in_dc_voltage_code = '0;
  logic [9:0]          in_gas_voltage_code = '0;
  logic [9:0]          in_flame_code = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_relay_dc_on;
  logic                out_relay_ac_on;
  logic                out_cooling_active;
  logic                out_low_battery;
  logic                out_temp_fault;
  logic                out_alarm;

  // sideband for directed rows whose result is typed in
  bit      pin_valid = 1'b0;
  result_t pin_want = '0;

  bit no_gaps = 1'b0;
  int hold_reqs = 0;
  int hold_taken = 0;
  int hold_left = 0;

  // thermostat model: settings and state as the block should hold them
  cfg_t model_cfg = CFG_DEFAULTS;
  logic st_dc_relay, st_ac_relay, st_running, st_batt_low, st_flame_seen;
  result_t pending_results [$];

  cfg_t drv_cfg = CFG_DEFAULTS;
  int err_count = 0;
  int quiet_cycles = 0;
  int rounds_in = 0, results_out = 0, settings_used = 1;
  int dc_on_cnt = 0, ac_on_cnt = 0, low_bat_cnt = 0, alarm_cnt = 0;
  string field_names [6] = '{"relay_dc_on", "relay_ac_on", "cooling_active",
                             "low_battery", "temp_fault", "alarm"};

  hysteresis_cooling_thermostat u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_temperature     (in_temperature),
    .in_sensor_error    (in_sensor_error),
    .in_dc_voltage_code (in_dc_voltage_code),
    .in_gas_voltage_code(in_gas_voltage_code),
    .in_flame_code      (in_flame_code),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_relay_dc_on    (out_relay_dc_on),
    .out_relay_ac_on    (out_relay_ac_on),
    .out_cooling_active (out_cooling_active),
    .out_low_battery    (out_low_battery),
    .out_temp_fault     (out_temp_fault),
    .out_alarm          (out_alarm)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One measurement round through the model; updates the model state.
  function automatic result_t thermostat_round(input meas_t m);
    result_t r;
    int      t, setp;
    logic    gas_md, dc_md, rel;
    t = $signed(m.temperature);
    setp = $signed(model_cfg.set_temp);
    gas_md = (model_cfg.op_mode == MODE_GAS);
    dc_md = (model_cfg.op_mode == MODE_DC);
    if (!gas_md) begin
      rel = dc_md ? st_dc_relay : st_ac_relay;
      // previous round's battery flag can force the cooler off
      if (t <= setp - int'(model_cfg.off_margin) || st_batt_low) begin
        rel = 1'b0;
        st_running = 1'b0;
      end else if (t >= setp + int'(model_cfg.on_margin)) begin
        rel = 1'b1;
        st_running = 1'b1;
      end
      st_dc_relay = dc_md & rel;
      st_ac_relay = !dc_md & rel;
    end else begin
      st_dc_relay = 1'b0;
      st_ac_relay = 1'b0;
    end
    if (gas_md) st_batt_low = m.gas_voltage_code < model_cfg.gas_low_limit;
    else if (dc_md) st_batt_low = m.dc_voltage_code < model_cfg.dc_low_limit;
    else st_batt_low = 1'b0;
    if (gas_md) begin
      st_running = m.flame_code <= model_cfg.flame_out_limit;
      if (st_running) st_flame_seen = 1'b1;
    end
    r.relay_dc_on = st_dc_relay;
    r.relay_ac_on = st_ac_relay;
    r.cooling_active = st_running;
    r.low_battery = st_batt_low;
    r.temp_fault = m.sensor_error;
    r.alarm = (st_batt_low && (gas_md || dc_md)) || m.sensor_error ||
              (st_flame_seen && !st_running);
    return r;
  endfunction

  task automatic log_error(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("ERROR: %s", msg);
  endtask

  // scoreboard, model update and watchdog, all sampled at the rising edge
  always @(posedge clk) begin : scoreboard
    meas_t   m;
    result_t got, want;
    if (!rst_n) begin
      model_cfg = CFG_DEFAULTS;
      st_dc_relay = 1'b0;
      st_ac_relay = 1'b0;
      st_running = 1'b0;
      st_batt_low = 1'b1;
      st_flame_seen = 1'b0;
      pending_results.delete();
      quiet_cycles = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OP_MODE:    model_cfg.op_mode = cfg_data[1:0];
          CFG_SET_TEMP:   model_cfg.set_temp = cfg_data[TempW-1:0];
          CFG_ON_MARGIN:  model_cfg.on_margin = cfg_data[MarginW-1:0];
          CFG_OFF_MARGIN: model_cfg.off_margin = cfg_data[MarginW-1:0];
          CFG_GAS_LOW:    model_cfg.gas_low_limit = cfg_data[CodeW-1:0];
          CFG_DC_LOW:     model_cfg.dc_low_limit = cfg_data[CodeW-1:0];
          CFG_FLAME_OUT:  model_cfg.flame_out_limit = cfg_data[CodeW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        m = {in_temperature, in_sensor_error, in_dc_voltage_code, in_gas_voltage_code,
             in_flame_code};
        want = thermostat_round(m);
        pending_results.push_back(pin_valid ? pin_want : want);
        rounds_in++;
      end
      if (out_valid && out_ready) begin
        got = {out_relay_dc_on, out_relay_ac_on, out_cooling_active, out_low_battery,
               out_temp_fault, out_alarm};
        if (pending_results.size() == 0) begin
          log_error($sformatf("result beat %0d with nothing pending", results_out));
        end else begin
          want = pending_results.pop_front();
          for (int b = 0; b < 6; b++) begin
            if (got[5-b] !== want[5-b])
              log_error($sformatf("result %0d: %s got %b, expected %b", results_out,
                                  field_names[b], got[5-b], want[5-b]));
          end
          dc_on_cnt += want.relay_dc_on;
          ac_on_cnt += want.relay_ac_on;
          low_bat_cnt += want.low_battery;
          alarm_cnt += want.alarm;
        end
        results_out++;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results pending", quiet_cycles,
                 pending_results.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // result side: random stalls, plus one long hold-off per request from the sender
  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_taken <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_reqs) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_taken <= hold_reqs;
    end else begin
      out_ready <= no_gaps || ($urandom_range(99) >= 6);
    end
  end

  // Offer one beat and wait for it to be taken; valid stays high for a following beat.
  task automatic send_round(input meas_t m, input bit pinned, input result_t want);
    in_valid <= 1'b1;
    in_temperature <= m.temperature;
    in_sensor_error <= m.sensor_error;
    in_dc_voltage_code <= m.dc_voltage_code;
    in_gas_voltage_code <= m.gas_voltage_code;
    in_flame_code <= m.flame_code;
    pin_valid <= pinned;
    pin_want <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending and wait until every pending result has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // caller drops cfg_we after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    write_reg(CFG_OP_MODE, CfgDataW'(c.op_mode));
    write_reg(CFG_SET_TEMP, c.set_temp);
    write_reg(CFG_ON_MARGIN, CfgDataW'(c.on_margin));
    write_reg(CFG_OFF_MARGIN, CfgDataW'(c.off_margin));
    write_reg(CFG_GAS_LOW, CfgDataW'(c.gas_low_limit));
    write_reg(CFG_DC_LOW, CfgDataW'(c.dc_low_limit));
    write_reg(CFG_FLAME_OUT, CfgDataW'(c.flame_out_limit));
    cfg_we <= 1'b0;
    drv_cfg = c;
    settings_used++;
  endtask

  function automatic dir_row_t mk_row(input logic [1:0] mode, input int temp, input bit err,
                                      input int dc, input int gas, input int flame,
                                      input bit pinned, input result_t want);
    dir_row_t r;
    r.mode = mode;
    r.m.temperature = temp[11:0];
    r.m.sensor_error = err;
    r.m.dc_voltage_code = dc[9:0];
    r.m.gas_voltage_code = gas[9:0];
    r.m.flame_code = flame[9:0];
    r.pinned = pinned;
    r.want = want;
    return r;
  endfunction

  function automatic cfg_t phase_settings(input int ph);
    cfg_t c;
    c.op_mode = PHASE_MODES[ph];
    if (ph == 0) begin
      c.set_temp = TEMP_MIN[11:0];
      c.on_margin = '0;
      c.off_margin = '0;
      c.gas_low_limit = '0;
      c.dc_low_limit = '0;
      c.flame_out_limit = '0;
    end else if (ph == 1) begin
      c.set_temp = TEMP_MAX[11:0];
      c.on_margin = '1;
      c.off_margin = '1;
      c.gas_low_limit = '1;
      c.dc_low_limit = '1;
      c.flame_out_limit = '1;
    end else begin
      c.set_temp = 12'(int'($urandom_range(TEMP_MAX - TEMP_MIN)) + TEMP_MIN);
      c.on_margin = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(24));
      c.off_margin = $urandom_range(1) ? 8'($urandom_range(255)) : 8'($urandom_range(24));
      c.gas_low_limit = 10'($urandom_range(900, 200));
      c.dc_low_limit = 10'($urandom_range(900, 200));
      c.flame_out_limit = 10'($urandom_range(900, 100));
    end
    return c;
  endfunction

  // mostly a healthy supply code, sometimes right at the threshold
  function automatic logic [9:0] pick_code(input logic [9:0] limit);
    int sel, c;
    sel = $urandom_range(99);
    if (sel < 80) c = $urandom_range(CODE_MAX, limit);
    else if (sel < 90) c = int'(limit) + int'($urandom_range(6)) - 3;
    else c = $urandom_range(CODE_MAX);
    if (c < 0) c = 0;
    if (c > CODE_MAX) c = CODE_MAX;
    return c[9:0];
  endfunction

  function automatic meas_t random_round();
    meas_t m;
    int    lo, hi, t, lim, sel;
    if ($urandom_range(99) < 75) begin
      // keep most temperatures around the hysteresis band
      lo = $signed(drv_cfg.set_temp) - int'(drv_cfg.off_margin) - 6;
      hi = $signed(drv_cfg.set_temp) + int'(drv_cfg.on_margin) + 6;
      if (lo < TEMP_MIN) lo = TEMP_MIN;
      if (hi > TEMP_MAX) hi = TEMP_MAX;
      t = lo + int'($urandom_range(hi - lo));
    end else begin
      t = int'($urandom_range(TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
    end
    m.temperature = t[11:0];
    m.sensor_error = ($urandom_range(99) < 8);
    m.dc_voltage_code = pick_code(drv_cfg.dc_low_limit);
    m.gas_voltage_code = pick_code(drv_cfg.gas_low_limit);
    lim = drv_cfg.flame_out_limit;
    sel = $urandom_range(99);
    if (sel < 45) m.flame_code = 10'($urandom_range(lim, 0));
    else if (sel < 90 && lim < CODE_MAX) m.flame_code = 10'($urandom_range(CODE_MAX, lim + 1));
    else m.flame_code = 10'($urandom_range(CODE_MAX));
    return m;
  endfunction

  initial begin : stimulus
    dir_row_t rows [$];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // result bits: dc ac cooling low_battery temp_fault alarm
    // gas mode on reset settings: flame and gas thresholds, flame lost after seen
    rows.push_back(mk_row(MODE_GAS,    0, 0,    0, 1023,    0, 1, 6'b001000));
    rows.push_back(mk_row(MODE_GAS, 2000, 0, 1023, 1023, 1023, 1, 6'b000001));
    rows.push_back(mk_row(MODE_GAS, -880, 0,    0,    0,  409, 1, 6'b001101));
    rows.push_back(mk_row(MODE_GAS,    0, 0,  512,  723,  410, 1, 6'b000001));
    rows.push_back(mk_row(MODE_GAS,   -1, 1, 1023,  722,    0, 1, 6'b001111));
    rows.push_back(mk_row(MODE_GAS,    1, 0,  341,  341,  682, 1, 6'b000101));
    rows.push_back(mk_row(MODE_GAS, 1365, 0,  682, 1023,  341, 1, 6'b001000));
    // DC: running carried over from gas, band edges, hold, battery lockout next round
    rows.push_back(mk_row(MODE_DC,     0, 0, 1023, 0, 0, 0, '0));
    rows.push_back(mk_row(MODE_DC,     8, 0, 1023, 0, 0, 0, '0));
    rows.push_back(mk_row(MODE_DC,   -15, 0, 1023, 0, 0, 0, '0));
    rows.push_back(mk_row(MODE_DC,   -16, 0, 1023, 0, 0, 0, '0));
    rows.push_back(mk_row(MODE_DC,     7, 0, 1023, 0, 0, 0, '0));
    rows.push_back(mk_row(MODE_DC,  2000, 0,  671, 0, 0, 0, '0));
    rows.push_back(mk_row(MODE_DC,  2000, 0,  672, 0, 0, 0, '0));
    rows.push_back(mk_row(MODE_DC,  2000, 1, 1023, 0, 0, 0, '0));
    // AC ignores the supply codes; the spare mode code acts as AC
    rows.push_back(mk_row(MODE_AC,     0, 0,    0, 0, 0, 0, '0));
    rows.push_back(mk_row(MODE_AC,  2000, 0,    0, 0, 0, 0, '0));
    rows.push_back(mk_row(MODE_AC,  -880, 0,    0, 0, 0, 0, '0));
    rows.push_back(mk_row(MODE_SPARE, 2000, 0,  0, 0, 0, 0, '0));
    rows.push_back(mk_row(MODE_SPARE,  -16, 0,  0, 0, 0, 0, '0));
    rows.push_back(mk_row(MODE_GAS,    0, 0, 1023, 1023, 1023, 0, '0));

    foreach (rows[i]) begin
      if (rows[i].mode != drv_cfg.op_mode) begin
        settle();
        write_reg(CFG_OP_MODE, CfgDataW'(rows[i].mode));
        cfg_we <= 1'b0;
        drv_cfg.op_mode = rows[i].mode;
        settings_used++;
      end
      send_round(rows[i].m, rows[i].pinned, rows[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      load_settings(phase_settings(ph));
      no_gaps <= (ph == 6);
      // output held off while beats keep coming, so the pipe fills and backs up
      if (ph == 3) hold_reqs <= hold_reqs + 1;
      for (int k = 0; k < ROUNDS_PER_PHASE; k++) begin
        if (ph == 5 && k == ROUNDS_PER_PHASE / 2) settle();
        else if (ph != 6 && $urandom_range(99) < 6) idle_sender(1);
        send_round(random_round(), 1'b0, '0);
      end
    end

    settle();
    $display("%0d measurement rounds over %0d settings, %0d results checked",
             rounds_in, settings_used, results_out);
    $display("results with dc relay on %0d, ac relay on %0d, low battery %0d, alarm %0d",
             dc_on_cnt, ac_on_cnt, low_bat_cnt, alarm_cnt);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
